// ----- design/assert_macros.svh -----
// Assertion macros shared by the standstill ramp design.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check under reset gating
`define SMSR_CHECK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("check failed");
// Check that also holds while reset is asserted
`define SMSR_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("check failed");
`else
`define SMSR_CHECK(lbl, clk, rstn, prop)
`define SMSR_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/smsr_pkg.sv -----
// Shared types, constants and helpers for the standstill motion-state ramp.
// No dependencies; used by every module of the block.
package smsr_pkg;

    // Motion mode, one-hot
    typedef enum logic [4:0] {
        MODE_MOVE  = 5'b00001,
        MODE_STOP  = 5'b00010,
        MODE_STAND = 5'b00100,
        MODE_HOLD  = 5'b01000,
        MODE_START = 5'b10000
    } t_mode;

    // External mode codes
    localparam logic [2:0] CODE_MOVE  = 3'd0;
    localparam logic [2:0] CODE_STOP  = 3'd1;
    localparam logic [2:0] CODE_STAND = 3'd2;
    localparam logic [2:0] CODE_HOLD  = 3'd3;
    localparam logic [2:0] CODE_START = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_TICK_TIME = 2'd0;
    localparam logic [1:0] CFG_HOLD_TIME = 2'd1;
    localparam logic [1:0] CFG_RAMP_STEP = 2'd2;

    // Thresholds in mm/s and mm/s^2
    localparam logic signed [15:0] SPEED_STOP_MAX  = 16'sd300;
    localparam logic signed [15:0] ACCEL_STOP_MAX  = -16'sd10;
    localparam logic signed [15:0] ACCEL_START_MIN = 16'sd300;
    localparam logic signed [15:0] ACCEL_RAMP_MAX  = -16'sd300;

    // Status of one tick, passed from mode logic to ramp and output stage
    typedef struct packed {
        logic       stop_out;
        logic       standing;
        logic       holding;
        logic [2:0] mode_code;
    } t_mode_status;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        begin
            unique case (m)
                MODE_STOP:  c = CODE_STOP;
                MODE_STAND: c = CODE_STAND;
                MODE_HOLD:  c = CODE_HOLD;
                MODE_START: c = CODE_START;
                default:    c = CODE_MOVE;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- design/standstill_motion_state_ramp_top.sv -----
// Standstill motion-state ramp: input register, mode and ramp logic, result register.
// Depends on smsr_pkg, smsr_mode, smsr_ramp and assert_macros.svh.
//
// Usage: one beat on the slave stream is one control tick. Each accepted beat
// yields exactly one result beat on the master stream, in order.
// Configuration is written through the cfg channel (index 0 tick time,
// 1 hold detect time, 2 ramp step); it is ready whenever reset is released and
// should only be written while no tick is in flight.
// Path: an accepted beat is captured in the input register, then in the result
// register, which presents it on the master stream until it is taken.
// Throughput: one beat per cycle while the master side is ready; the mode,
// timer and last-output registers feed their next values back combinationally.
// Stall: while the master side is not ready, the result register holds and
// the input register still takes one more beat; further input is then
// refused until the result is taken.
// Reset: synchronous, active low; mode returns to move, timer and last
// output to zero, registers to 20 / 2000 / 50, and both stages empty.
// Neither the slave stream nor the cfg channel is ready while reset is held.
`include "assert_macros.svh"
module standstill_motion_state_ramp_top #(
    parameter int TIMER_MAX = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] control_enabled, [1] at_standstill, [17:2] ego_speed,
    // [33:18] demand_accel, [34] start_confirm, [35] driver_min_flag, rest zero
    input  logic [39:0] s_axis_tdata,
    // Master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] cmd_accel, [16] cmd_enabled, [17] stop_request, [18] start_request,
    // [19] standing_state, [20] holding_state, [21] driver_min_out,
    // [24:22] mode_out, rest zero
    output logic [31:0] m_axis_tdata,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import smsr_pkg::*;

    // Input stage
    logic        r_in_valid;
    logic [35:0] r_in;
    logic        w_adv;

    // Configuration
    logic [9:0]  r_tick_time;
    logic [15:0] r_hold_time;
    logic [14:0] r_ramp_step;

    // Result stage
    logic        r_out_valid;
    logic [24:0] r_out;

    // Decoded fields
    logic               w_en, w_ss, w_conf, w_dmin;
    logic signed [15:0] w_speed, w_demand, w_accel;
    logic               w_stop_cond, w_start_req;
    t_mode_status       w_status;

    assign w_en     = r_in[0];
    assign w_ss     = r_in[1];
    assign w_speed  = r_in[17:2];
    assign w_demand = r_in[33:18];
    assign w_conf   = r_in[34];
    assign w_dmin   = r_in[35];

    assign w_stop_cond = (w_speed < SPEED_STOP_MAX) && (w_demand < ACCEL_STOP_MAX);
    assign w_start_req = (w_demand > ACCEL_START_MIN);

    // Advance when a tick waits and the result register is free
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || w_adv);
    assign o_cfg_ready   = i_rst_n;

    // Capture input beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[35:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_time <= 10'd20;
            r_hold_time <= 16'd2000;
            r_ramp_step <= 15'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_TIME: r_tick_time <= i_cfg_data[9:0];
                CFG_HOLD_TIME: r_hold_time <= i_cfg_data;
                CFG_RAMP_STEP: r_ramp_step <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    smsr_mode #(
        .TIMER_MAX (TIMER_MAX)
    ) u_mode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_enabled       (w_en),
        .i_standstill    (w_ss),
        .i_stop_cond     (w_stop_cond),
        .i_start_req     (w_start_req),
        .i_start_confirm (w_conf),
        .i_tick_time     (r_tick_time),
        .i_hold_time     (r_hold_time),
        .o_status        (w_status)
    );

    smsr_ramp u_ramp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_stop_out (w_status.stop_out),
        .i_demand   (w_demand),
        .i_step     (r_ramp_step),
        .o_accel    (w_accel)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {w_status.mode_code, w_dmin, w_status.holding, w_status.standing,
                      w_start_req, w_status.stop_out, w_en, w_accel};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out};

    // Checks
    `SMSR_CHECK(a_no_adv_on_stall, i_clk, i_rst_n, !(w_adv && r_out_valid && !m_axis_tready))
    `SMSR_CHECK(a_busy_means_full, i_clk, i_rst_n, !s_axis_tready |-> r_in_valid)
    `SMSR_CHECK(a_hold_is_standing, i_clk, i_rst_n, r_out_valid && r_out[20] |-> r_out[19])
    `SMSR_ALWAYS(a_stop_needs_enable, i_clk, w_status.stop_out |-> w_en)

endmodule

// ----- design/smsr_mode.sv -----
// Motion mode state machine and saturating standstill timer.
// Depends on smsr_pkg.
module smsr_mode #(
    parameter int TIMER_MAX = 65535
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_enabled,
    input  logic                      i_standstill,
    input  logic                      i_stop_cond,
    input  logic                      i_start_req,
    input  logic                      i_start_confirm,
    input  logic [9:0]                i_tick_time,
    input  logic [15:0]               i_hold_time,
    output smsr_pkg::t_mode_status    o_status
);
    import smsr_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_timer, n_timer;
    logic [16:0] w_sum;
    logic [15:0] w_grown;

    // Saturating timer growth
    assign w_sum   = {1'b0, r_timer} + {7'b0, i_tick_time};
    assign w_grown = (w_sum > 17'(TIMER_MAX)) ? 16'(TIMER_MAX) : w_sum[15:0];

    // Next mode and timer
    always_comb begin
        n_mode  = r_mode;
        n_timer = r_timer;
        if (i_enabled) begin
            unique case (r_mode)
                MODE_STOP: begin
                    if (i_standstill) n_mode = MODE_STAND;
                    n_timer = '0;
                end
                MODE_STAND: begin
                    if (!i_standstill) n_mode = MODE_MOVE;
                    else if (i_start_req) n_mode = MODE_START;
                    else if (r_timer > i_hold_time) n_mode = MODE_HOLD;
                    n_timer = w_grown;
                end
                MODE_HOLD: begin
                    if (!i_standstill) n_mode = MODE_MOVE;
                    else if (i_start_req && i_start_confirm) n_mode = MODE_START;
                    n_timer = w_grown;
                end
                MODE_START: begin
                    if (!i_standstill) n_mode = MODE_MOVE;
                    n_timer = w_grown;
                end
                default: begin
                    if (i_standstill) n_mode = MODE_STAND;
                    else if (i_stop_cond) n_mode = MODE_STOP;
                    else n_mode = MODE_MOVE;
                    n_timer = '0;
                end
            endcase
        end else begin
            n_mode = i_standstill ? MODE_HOLD : MODE_MOVE;
        end
    end

    // Status of the new mode
    always_comb begin
        o_status.stop_out  = i_enabled && ((n_mode == MODE_STOP) ||
                             (n_mode == MODE_STAND) || (n_mode == MODE_HOLD));
        o_status.standing  = (n_mode == MODE_STAND) || (n_mode == MODE_HOLD);
        o_status.holding   = (n_mode == MODE_HOLD);
        o_status.mode_code = mode_code(n_mode);
    end

    // Commit state when a beat advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MOVE;
            r_timer <= '0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
        end
    end

endmodule

// ----- design/smsr_ramp.sv -----
// Deceleration ramp toward min(demand, -300 mm/s^2) and the last-output register.
// Depends on smsr_pkg.
module smsr_ramp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_stop_out,
    input  logic signed [15:0] i_demand,
    input  logic [14:0]        i_step,
    output logic signed [15:0] o_accel
);
    import smsr_pkg::*;

    logic signed [15:0] r_last;
    logic signed [15:0] w_target;
    logic signed [16:0] w_up, w_down, w_target17;
    logic signed [15:0] w_ramped;

    assign w_target   = (i_demand < ACCEL_RAMP_MAX) ? i_demand : ACCEL_RAMP_MAX;
    assign w_target17 = {w_target[15], w_target};
    assign w_up       = {r_last[15], r_last} + $signed({2'b00, i_step});
    assign w_down     = {r_last[15], r_last} - $signed({2'b00, i_step});

    // Step toward the target without passing it
    always_comb begin
        if (r_last < w_target) begin
            w_ramped = (w_up > w_target17) ? w_target : w_up[15:0];
        end else if (r_last > w_target) begin
            w_ramped = (w_down < w_target17) ? w_target : w_down[15:0];
        end else begin
            w_ramped = r_last;
        end
    end

    assign o_accel = i_stop_out ? w_ramped : i_demand;

    // Hold the last output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_adv) begin
            r_last <= o_accel;
        end
    end

endmodule
